FILE: hw/rtl/rro_pkg.sv
// Shared constants, widths and the sine/cosine table for the rotated rectangle overlap test.
`timescale 1ns / 1ps

package rro_pkg;

  // Coordinate and trig formats.
  localparam int COORD_BITS     = 24;
  localparam int TRIG_FRAC_BITS = 15;

  localparam int SIZE_BITS = COORD_BITS - 1;       // full sizes, unsigned
  localparam int DIFF_BITS = COORD_BITS + 2;       // doubled center differences
  localparam int INT_BITS  = COORD_BITS + 6;       // internal signed Q.1 coordinates (half units)
  localparam int MAG_BITS  = COORD_BITS + 5;       // divider operand magnitudes
  localparam int TRIG_BITS = TRIG_FRAC_BITS + 2;   // signed trig value
  localparam int TMAG_BITS = TRIG_FRAC_BITS + 1;   // unsigned table value
  localparam int PROD_BITS = TRIG_BITS + DIFF_BITS + 1;

  // Angles in sixteenths of a degree.
  localparam int ANG_BITS      = 13;
  localparam int IDX_BITS      = 10;
  localparam int ANGLE_STEPS   = 5760;
  localparam int QUARTER_STEPS = 1440;
  localparam int EIGHTH_STEPS  = 720;
  localparam int HALF_STEPS    = 2880;

  // Divider timing: operand stage, product, range check, one bit per step, result.
  localparam int DIV_LAT = MAG_BITS + 4;

  localparam logic [MAG_BITS-1:0] QUOT_LIM = MAG_BITS'(1) << (COORD_BITS + 4);
  localparam logic signed [PROD_BITS-1:0] RND_HALF = PROD_BITS'(1) << (TRIG_FRAC_BITS - 1);

  localparam int TENT_BITS = 2 * TMAG_BITS;
  typedef logic [TENT_BITS-1:0] trig_rom_t [EIGHTH_STEPS+1];

  // Sine and cosine over the first octant, built at elaboration from a
  // truncating Taylor evaluation in Q30 and rounded to the trig format.
  function automatic trig_rom_t build_trig_rom();
    trig_rom_t rom;
    logic [63:0] th;
    logic [63:0] r2;
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] one;
    logic [63:0] half;
    one  = 64'd1 << 30;
    half = 64'd1 << (29 - TRIG_FRAC_BITS);
    for (int r = 0; r <= EIGHTH_STEPS; r++) begin
      th = (64'(r) * 64'd3373259426) / 64'd2880;
      r2 = (th * th) >> 30;
      h  = one - r2 / 64'd110;
      h  = one - ((r2 * h) >> 30) / 64'd72;
      h  = one - ((r2 * h) >> 30) / 64'd42;
      h  = one - ((r2 * h) >> 30) / 64'd20;
      h  = one - ((r2 * h) >> 30) / 64'd6;
      s  = (th * h) >> 30;
      h  = one - r2 / 64'd132;
      h  = one - ((r2 * h) >> 30) / 64'd90;
      h  = one - ((r2 * h) >> 30) / 64'd56;
      h  = one - ((r2 * h) >> 30) / 64'd30;
      h  = one - ((r2 * h) >> 30) / 64'd12;
      c  = one - ((r2 * h) >> 30) / 64'd2;
      s  = (s + half) >> (30 - TRIG_FRAC_BITS);
      c  = (c + half) >> (30 - TRIG_FRAC_BITS);
      rom[r] = {s[TMAG_BITS-1:0], c[TMAG_BITS-1:0]};
    end
    return rom;
  endfunction

  localparam trig_rom_t TRIG_ROM = build_trig_rom();

endpackage

FILE: hw/rtl/rotated_rectangle_overlap_test.sv
// Top level of the rotated rectangle overlap test pipeline.
`timescale 1ns / 1ps

// Usage:
//   Drive the two rectangles (center, full width, full height, angle) and
//   raise start; a transfer takes place at every rising edge where start is
//   high and busy is low. busy stays low, so a new pair may enter in every
//   cycle and the block sustains one pair per clock.
//   Each pair produces exactly one result: done_o pulses high for one cycle
//   with overlap_o valid in that same cycle, in the order the pairs entered.
//   A pair passes the input and angle stages, the sine/cosine table read,
//   the multiplier and rounding stages, the pair of pipelined dividers (one
//   quotient bit per stage) and the final vertical range test, in that order.
//   Reset clears only the valid bits, so no stale result appears after it.
//   The receiver cannot stall; results must be taken when done_o is high.

module rotated_rectangle_overlap_test import rro_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] first_center_x_i,
  input  logic signed [COORD_BITS-1:0] first_center_y_i,
  input  logic        [SIZE_BITS-1:0]  first_width_i,
  input  logic        [SIZE_BITS-1:0]  first_height_i,
  input  logic        [ANG_BITS-1:0]   first_angle_i,
  input  logic signed [COORD_BITS-1:0] second_center_x_i,
  input  logic signed [COORD_BITS-1:0] second_center_y_i,
  input  logic        [SIZE_BITS-1:0]  second_width_i,
  input  logic        [SIZE_BITS-1:0]  second_height_i,
  input  logic        [ANG_BITS-1:0]   second_angle_i,
  output logic                         done_o,
  output logic                         overlap_o
);

  localparam int NPRE = 11;

  typedef struct packed {
    logic [1:0]          quad;
    logic                swap;
    logic [IDX_BITS-1:0] idx;
  } oct_t;

  typedef struct packed {
    logic signed [TRIG_BITS-1:0] s;
    logic signed [TRIG_BITS-1:0] c;
  } sc_t;

  // Octant reduction of an angle.
  function automatic oct_t split_angle(input logic [ANG_BITS-1:0] q);
    oct_t o;
    logic [ANG_BITS-1:0] r;
    if (q >= ANG_BITS'(3 * QUARTER_STEPS)) begin
      o.quad = 2'd3;
      r = q - ANG_BITS'(3 * QUARTER_STEPS);
    end else if (q >= ANG_BITS'(2 * QUARTER_STEPS)) begin
      o.quad = 2'd2;
      r = q - ANG_BITS'(2 * QUARTER_STEPS);
    end else if (q >= ANG_BITS'(QUARTER_STEPS)) begin
      o.quad = 2'd1;
      r = q - ANG_BITS'(QUARTER_STEPS);
    end else begin
      o.quad = 2'd0;
      r = q;
    end
    o.swap = (r > ANG_BITS'(EIGHTH_STEPS));
    o.idx  = o.swap ? IDX_BITS'(ANG_BITS'(QUARTER_STEPS) - r) : r[IDX_BITS-1:0];
    return o;
  endfunction

  // Octant and quadrant symmetry on a table entry.
  function automatic sc_t apply_quad(input logic [TENT_BITS-1:0] e, input logic swap,
                                     input logic [1:0] quad);
    sc_t o;
    logic signed [TRIG_BITS-1:0] s;
    logic signed [TRIG_BITS-1:0] c;
    s = $signed({1'b0, e[TENT_BITS-1:TMAG_BITS]});
    c = $signed({1'b0, e[TMAG_BITS-1:0]});
    if (swap) begin
      o.s = c;
      o.c = s;
      s = o.s;
      c = o.c;
    end
    case (quad)
      2'd0: begin o.s = s;  o.c = c;  end
      2'd1: begin o.s = c;  o.c = -s; end
      2'd2: begin o.s = -s; o.c = -c; end
      default: begin o.s = -c; o.c = s; end
    endcase
    return o;
  endfunction

  // Round a trig-scaled sum back to coordinate units (half up, floor).
  function automatic logic signed [INT_BITS-1:0] rnd(input logic signed [PROD_BITS-1:0] v);
    logic signed [PROD_BITS-1:0] t;
    t = (v + RND_HALF) >>> TRIG_FRAC_BITS;
    return t[INT_BITS-1:0];
  endfunction

  logic [NPRE-1:0] pv_q;

  // Stage 0: input capture.
  logic signed [COORD_BITS-1:0] x1_0_q, y1_0_q, x2_0_q, y2_0_q;
  logic [SIZE_BITS-1:0] w1_0_q, h1_0_q, w2_0_q, h2_0_q;
  logic [ANG_BITS-1:0]  a1_0_q, a2_0_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i) begin
    x1_0_q <= first_center_x_i;
    y1_0_q <= first_center_y_i;
    w1_0_q <= first_width_i;
    h1_0_q <= first_height_i;
    a1_0_q <= first_angle_i;
    x2_0_q <= second_center_x_i;
    y2_0_q <= second_center_y_i;
    w2_0_q <= second_width_i;
    h2_0_q <= second_height_i;
    a2_0_q <= second_angle_i;
  end

  // Stage 1: angle wrap and doubled center differences.
  logic [ANG_BITS-1:0] a1_1_q, a2_1_q;
  logic signed [DIFF_BITS-1:0] dx_1_q, dy_1_q;
  logic [SIZE_BITS-1:0] w1_1_q, h1_1_q, w2_1_q, h2_1_q;
  logic signed [COORD_BITS:0] ddx, ddy;

  assign ddx = $signed({x2_0_q[COORD_BITS-1], x2_0_q}) - $signed({x1_0_q[COORD_BITS-1], x1_0_q});
  assign ddy = $signed({y2_0_q[COORD_BITS-1], y2_0_q}) - $signed({y1_0_q[COORD_BITS-1], y1_0_q});

  always_ff @(posedge clk_i) begin
    a1_1_q <= (a1_0_q >= ANG_BITS'(ANGLE_STEPS)) ? a1_0_q - ANG_BITS'(ANGLE_STEPS) : a1_0_q;
    a2_1_q <= (a2_0_q >= ANG_BITS'(ANGLE_STEPS)) ? a2_0_q - ANG_BITS'(ANGLE_STEPS) : a2_0_q;
    dx_1_q <= {ddx, 1'b0};
    dy_1_q <= {ddy, 1'b0};
    w1_1_q <= w1_0_q;
    h1_1_q <= h1_0_q;
    w2_1_q <= w2_0_q;
    h2_1_q <= h2_0_q;
  end

  // Stage 2: angle difference.
  logic [ANG_BITS-1:0] ad_2_q, a2_2_q;
  logic signed [DIFF_BITS-1:0] dx_2_q, dy_2_q;
  logic [SIZE_BITS-1:0] w1_2_q, h1_2_q, w2_2_q, h2_2_q;
  logic [ANG_BITS:0] adiff;

  assign adiff = {1'b0, a1_1_q} - {1'b0, a2_1_q};

  always_ff @(posedge clk_i) begin
    ad_2_q <= adiff[ANG_BITS] ? ANG_BITS'(adiff + (ANG_BITS+1)'(ANGLE_STEPS))
                              : adiff[ANG_BITS-1:0];
    a2_2_q <= a2_1_q;
    dx_2_q <= dx_1_q;
    dy_2_q <= dy_1_q;
    w1_2_q <= w1_1_q;
    h1_2_q <= h1_1_q;
    w2_2_q <= w2_1_q;
    h2_2_q <= h2_1_q;
  end

  // Stage 3: octant reduction.
  oct_t o2_3_q, od_3_q;
  logic signed [DIFF_BITS-1:0] dx_3_q, dy_3_q;
  logic [SIZE_BITS-1:0] w1_3_q, h1_3_q, w2_3_q, h2_3_q;

  always_ff @(posedge clk_i) begin
    o2_3_q <= split_angle(a2_2_q);
    od_3_q <= split_angle(ad_2_q);
    dx_3_q <= dx_2_q;
    dy_3_q <= dy_2_q;
    w1_3_q <= w1_2_q;
    h1_3_q <= h1_2_q;
    w2_3_q <= w2_2_q;
    h2_3_q <= h2_2_q;
  end

  // Stage 4: table read.
  logic [TENT_BITS-1:0] e2_4_q, ed_4_q;
  logic [1:0] q2_4_q, qd_4_q;
  logic sw2_4_q, swd_4_q;
  logic signed [DIFF_BITS-1:0] dx_4_q, dy_4_q;
  logic [SIZE_BITS-1:0] w1_4_q, h1_4_q, w2_4_q, h2_4_q;

  always_ff @(posedge clk_i) begin
    e2_4_q  <= TRIG_ROM[o2_3_q.idx];
    ed_4_q  <= TRIG_ROM[od_3_q.idx];
    q2_4_q  <= o2_3_q.quad;
    qd_4_q  <= od_3_q.quad;
    sw2_4_q <= o2_3_q.swap;
    swd_4_q <= od_3_q.swap;
    dx_4_q  <= dx_3_q;
    dy_4_q  <= dy_3_q;
    w1_4_q  <= w1_3_q;
    h1_4_q  <= h1_3_q;
    w2_4_q  <= w2_3_q;
    h2_4_q  <= h2_3_q;
  end

  // Stage 5: signed sine and cosine.
  sc_t t2_5_q, td_5_q;
  logic signed [DIFF_BITS-1:0] dx_5_q, dy_5_q;
  logic [SIZE_BITS-1:0] w1_5_q, h1_5_q, w2_5_q, h2_5_q;

  always_ff @(posedge clk_i) begin
    t2_5_q <= apply_quad(e2_4_q, sw2_4_q, q2_4_q);
    td_5_q <= apply_quad(ed_4_q, swd_4_q, qd_4_q);
    dx_5_q <= dx_4_q;
    dy_5_q <= dy_4_q;
    w1_5_q <= w1_4_q;
    h1_5_q <= h1_4_q;
    w2_5_q <= w2_4_q;
    h2_5_q <= h2_4_q;
  end

  // Stage 6: products.
  logic signed [TRIG_BITS+DIFF_BITS-1:0]  c2dx_6_q, s2dy_6_q, c2dy_6_q, s2dx_6_q;
  logic signed [TRIG_BITS+COORD_BITS-1:0] w1cd_6_q, h1sd_6_q, h1cd_6_q, w1sd_6_q;
  logic signed [COORD_BITS-1:0] w1s, h1s;
  logic sdneg_6_q, cdneg_6_q, tzero_6_q;
  logic [SIZE_BITS-1:0] w2_6_q, h2_6_q;

  assign w1s = $signed({1'b0, w1_5_q});
  assign h1s = $signed({1'b0, h1_5_q});

  always_ff @(posedge clk_i) begin
    c2dx_6_q  <= t2_5_q.c * dx_5_q;
    s2dy_6_q  <= t2_5_q.s * dy_5_q;
    c2dy_6_q  <= t2_5_q.c * dy_5_q;
    s2dx_6_q  <= t2_5_q.s * dx_5_q;
    w1cd_6_q  <= w1s * td_5_q.c;
    h1sd_6_q  <= h1s * td_5_q.s;
    h1cd_6_q  <= h1s * td_5_q.c;
    w1sd_6_q  <= w1s * td_5_q.s;
    sdneg_6_q <= td_5_q.s[TRIG_BITS-1];
    cdneg_6_q <= td_5_q.c[TRIG_BITS-1];
    tzero_6_q <= (td_5_q.s == '0) || (td_5_q.c == '0);
    w2_6_q    <= w2_5_q;
    h2_6_q    <= h2_5_q;
  end

  // Stage 7: sums and rounding.
  logic signed [INT_BITS-1:0] cx_7_q, cy_7_q, ax_7_q, bx_7_q, ay_7_q, by_7_q;
  logic sdneg_7_q, cdneg_7_q, tzero_7_q;
  logic [SIZE_BITS-1:0] w2_7_q, h2_7_q;

  always_ff @(posedge clk_i) begin
    cx_7_q    <= rnd(PROD_BITS'(c2dx_6_q) + PROD_BITS'(s2dy_6_q));
    cy_7_q    <= rnd(PROD_BITS'(c2dy_6_q) - PROD_BITS'(s2dx_6_q));
    ax_7_q    <= rnd(PROD_BITS'(w1cd_6_q) - PROD_BITS'(h1sd_6_q));
    bx_7_q    <= rnd(-PROD_BITS'(h1sd_6_q) - PROD_BITS'(w1cd_6_q));
    ay_7_q    <= rnd(PROD_BITS'(h1cd_6_q) + PROD_BITS'(w1sd_6_q));
    by_7_q    <= rnd(PROD_BITS'(h1cd_6_q) - PROD_BITS'(w1sd_6_q));
    sdneg_7_q <= sdneg_6_q;
    cdneg_7_q <= cdneg_6_q;
    tzero_7_q <= tzero_6_q;
    w2_7_q    <= w2_6_q;
    h2_7_q    <= h2_6_q;
  end

  // Stage 8: box corners and vertex ordering.
  logic signed [INT_BITS-1:0] blx_8_q, bly_8_q, trx_8_q, try_8_q;
  logic signed [INT_BITS-1:0] ax_8_q, bx_8_q, ay_8_q, by_8_q;
  logic signed [INT_BITS-1:0] w2s, h2s, axs, bxs, ays, bys;
  logic tzero_8_q, tneg;

  assign w2s  = $signed({{(INT_BITS-SIZE_BITS){1'b0}}, w2_7_q});
  assign h2s  = $signed({{(INT_BITS-SIZE_BITS){1'b0}}, h2_7_q});
  assign tneg = !tzero_7_q && (sdneg_7_q != cdneg_7_q);

  always_comb begin
    axs = ax_7_q;
    bxs = bx_7_q;
    ays = ay_7_q;
    bys = by_7_q;
    if (tneg) begin
      axs = bx_7_q;
      bxs = ax_7_q;
      ays = by_7_q;
      bys = ay_7_q;
    end
    if (sdneg_7_q) begin
      bxs = -bxs;
      bys = -bys;
    end
  end

  always_ff @(posedge clk_i) begin
    blx_8_q   <= cx_7_q - w2s;
    bly_8_q   <= cy_7_q - h2s;
    trx_8_q   <= cx_7_q + w2s;
    try_8_q   <= cy_7_q + h2s;
    ax_8_q    <= axs;
    bx_8_q    <= bxs;
    ay_8_q    <= ays;
    by_8_q    <= bys;
    tzero_8_q <= tzero_7_q;
  end

  // Stage 9: horizontal rejection and span offsets.
  logic signed [INT_BITS-1:0] xs1_9_q, as1_9_q, xs2_9_q, as2_9_q;
  logic signed [INT_BITS-1:0] ax_9_q, bx_9_q, ay_9_q, by_9_q, bly_9_q, try_9_q;
  logic rej_9_q, tzero_9_q;

  always_ff @(posedge clk_i) begin
    rej_9_q   <= (bx_8_q > trx_8_q) || (bx_8_q > -blx_8_q);
    xs1_9_q   <= blx_8_q - ax_8_q;
    as1_9_q   <= trx_8_q - ax_8_q;
    xs2_9_q   <= blx_8_q + ax_8_q;
    as2_9_q   <= trx_8_q + ax_8_q;
    ax_9_q    <= ax_8_q;
    bx_9_q    <= bx_8_q;
    ay_9_q    <= ay_8_q;
    by_9_q    <= by_8_q;
    bly_9_q   <= bly_8_q;
    try_9_q   <= try_8_q;
    tzero_9_q <= tzero_8_q;
  end

  // Stage 10: interpolation operands for both vertical extremes.
  logic signed [INT_BITS-1:0] n1_10_q, x1_10_q, d1_10_q, n2_10_q, x2_10_q, d2_10_q;
  logic signed [INT_BITS-1:0] ay_10_q, bly_10_q, try_10_q;
  logic use1_10_q, use2_10_q, rej_10_q;
  logic use1, use2;

  assign use1 = !tzero_9_q && (xs1_9_q != '0) && (as1_9_q != '0)
                && (xs1_9_q[INT_BITS-1] == as1_9_q[INT_BITS-1]);
  assign use2 = !tzero_9_q && (xs2_9_q != '0) && (as2_9_q != '0)
                && (xs2_9_q[INT_BITS-1] == as2_9_q[INT_BITS-1]);

  always_ff @(posedge clk_i) begin
    if (xs1_9_q[INT_BITS-1]) begin
      d1_10_q <= ax_9_q - bx_9_q;
      n1_10_q <= ay_9_q - by_9_q;
      x1_10_q <= as1_9_q;
    end else begin
      d1_10_q <= ax_9_q + bx_9_q;
      n1_10_q <= ay_9_q + by_9_q;
      x1_10_q <= xs1_9_q;
    end
    if (xs2_9_q[INT_BITS-1]) begin
      d2_10_q <= -ax_9_q - bx_9_q;
      n2_10_q <= -ay_9_q - by_9_q;
      x2_10_q <= as2_9_q;
    end else begin
      d2_10_q <= -ax_9_q + bx_9_q;
      n2_10_q <= -ay_9_q + by_9_q;
      x2_10_q <= xs2_9_q;
    end
    use1_10_q <= use1;
    use2_10_q <= use2;
    rej_10_q  <= rej_9_q;
    ay_10_q   <= ay_9_q;
    bly_10_q  <= bly_9_q;
    try_10_q  <= try_9_q;
  end

  // Two dividers, one for each vertical extreme.
  logic signed [INT_BITS-1:0] quot1, quot2;

  rro_div u_div1 (
    .clk_i   (clk_i),
    .num_a_i (n1_10_q),
    .num_b_i (x1_10_q),
    .den_i   (d1_10_q),
    .quot_o  (quot1)
  );

  rro_div u_div2 (
    .clk_i   (clk_i),
    .num_a_i (n2_10_q),
    .num_b_i (x2_10_q),
    .den_i   (d2_10_q),
    .quot_o  (quot2)
  );

  // Side data that waits alongside the dividers.
  logic signed [INT_BITS-1:0] ay_dl_q  [DIV_LAT];
  logic signed [INT_BITS-1:0] bly_dl_q [DIV_LAT];
  logic signed [INT_BITS-1:0] try_dl_q [DIV_LAT];
  logic use1_dl_q [DIV_LAT];
  logic use2_dl_q [DIV_LAT];
  logic rej_dl_q  [DIV_LAT];
  logic [DIV_LAT-1:0] vdl_q;

  always_ff @(posedge clk_i) begin
    ay_dl_q[0]   <= ay_10_q;
    bly_dl_q[0]  <= bly_10_q;
    try_dl_q[0]  <= try_10_q;
    use1_dl_q[0] <= use1_10_q;
    use2_dl_q[0] <= use2_10_q;
    rej_dl_q[0]  <= rej_10_q;
    for (int k = 1; k < DIV_LAT; k++) begin
      ay_dl_q[k]   <= ay_dl_q[k-1];
      bly_dl_q[k]  <= bly_dl_q[k-1];
      try_dl_q[k]  <= try_dl_q[k-1];
      use1_dl_q[k] <= use1_dl_q[k-1];
      use2_dl_q[k] <= use2_dl_q[k-1];
      rej_dl_q[k]  <= rej_dl_q[k-1];
    end
  end

  // Stage E: vertical extremes.
  logic signed [INT_BITS-1:0] e1_e_q, e2_e_q, bly_e_q, try_e_q;
  logic rej_e_q, ve_q;

  always_ff @(posedge clk_i) begin
    e1_e_q  <= use1_dl_q[DIV_LAT-1] ? quot1 + ay_dl_q[DIV_LAT-1] : ay_dl_q[DIV_LAT-1];
    e2_e_q  <= use2_dl_q[DIV_LAT-1] ? quot2 - ay_dl_q[DIV_LAT-1] : -ay_dl_q[DIV_LAT-1];
    bly_e_q <= bly_dl_q[DIV_LAT-1];
    try_e_q <= try_dl_q[DIV_LAT-1];
    rej_e_q <= rej_dl_q[DIV_LAT-1];
  end

  // Stage F: vertical range test and result.
  logic hit_q, done_q;

  always_ff @(posedge clk_i) begin
    hit_q <= !rej_e_q && !(((e1_e_q < bly_e_q) && (e2_e_q < bly_e_q))
                        || ((e1_e_q > try_e_q) && (e2_e_q > try_e_q)));
  end

  // Valid bits travel with the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= '0;
      vdl_q  <= '0;
      ve_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pv_q   <= {pv_q[NPRE-2:0], start & ~busy};
      vdl_q  <= {vdl_q[DIV_LAT-2:0], pv_q[NPRE-1]};
      ve_q   <= vdl_q[DIV_LAT-1];
      done_q <= ve_q;
    end
  end

  assign done_o    = done_q;
  assign overlap_o = hit_q;

endmodule

FILE: hw/rtl/rro_div.sv
// Pipelined saturating multiply-divide: a * b / d, truncated toward zero.
`timescale 1ns / 1ps

module rro_div import rro_pkg::*; (
  input  logic                       clk_i,
  input  logic signed [INT_BITS-1:0] num_a_i,
  input  logic signed [INT_BITS-1:0] num_b_i,
  input  logic signed [INT_BITS-1:0] den_i,
  output logic signed [INT_BITS-1:0] quot_o
);

  logic [INT_BITS-1:0] abs_a, abs_b, abs_d;

  // Operand stage.
  logic [MAG_BITS-1:0] pa_q, pb_q, ma_q;
  logic zero_a_q, dz_a_q, nsg_a_q, neg_a_q;

  // Product stage.
  logic [2*MAG_BITS-1:0] prod_q;
  logic [MAG_BITS-1:0] mb_q;
  logic zero_b_q, dz_b_q, nsg_b_q, neg_b_q;

  // Bit steps.
  logic [MAG_BITS-1:0] rem_q  [MAG_BITS+1];
  logic [MAG_BITS-1:0] quo_q  [MAG_BITS+1];
  logic [MAG_BITS-1:0] lo_q   [MAG_BITS+1];
  logic [MAG_BITS-1:0] m_q    [MAG_BITS+1];
  logic                ovf_q  [MAG_BITS+1];
  logic                zero_q [MAG_BITS+1];
  logic                dz_q   [MAG_BITS+1];
  logic                nsg_q  [MAG_BITS+1];
  logic                neg_q  [MAG_BITS+1];

  logic [MAG_BITS:0]   trial  [MAG_BITS];
  logic                take   [MAG_BITS];

  logic [MAG_BITS-1:0]       mag_fin;
  logic signed [INT_BITS-1:0] res_d, res_q;
  logic signed [INT_BITS-1:0] lim_s;

  assign abs_a = num_a_i[INT_BITS-1] ? -num_a_i : num_a_i;
  assign abs_b = num_b_i[INT_BITS-1] ? -num_b_i : num_b_i;
  assign abs_d = den_i[INT_BITS-1]   ? -den_i   : den_i;

  // Magnitudes and sign handling.
  always_ff @(posedge clk_i) begin
    pa_q     <= abs_a[MAG_BITS-1:0];
    pb_q     <= abs_b[MAG_BITS-1:0];
    ma_q     <= abs_d[MAG_BITS-1:0];
    zero_a_q <= (num_a_i == '0) || (num_b_i == '0);
    dz_a_q   <= (den_i == '0);
    nsg_a_q  <= num_a_i[INT_BITS-1] ^ num_b_i[INT_BITS-1];
    neg_a_q  <= num_a_i[INT_BITS-1] ^ num_b_i[INT_BITS-1] ^ den_i[INT_BITS-1];
  end

  // Numerator product.
  always_ff @(posedge clk_i) begin
    prod_q   <= pa_q * pb_q;
    mb_q     <= ma_q;
    zero_b_q <= zero_a_q;
    dz_b_q   <= dz_a_q;
    nsg_b_q  <= nsg_a_q;
    neg_b_q  <= neg_a_q;
  end

  // Range check: a quotient at or above 2^MAG_BITS always saturates.
  always_ff @(posedge clk_i) begin
    ovf_q[0]  <= (prod_q[2*MAG_BITS-1:MAG_BITS] >= mb_q);
    rem_q[0]  <= prod_q[2*MAG_BITS-1:MAG_BITS];
    lo_q[0]   <= prod_q[MAG_BITS-1:0];
    quo_q[0]  <= '0;
    m_q[0]    <= mb_q;
    zero_q[0] <= zero_b_q;
    dz_q[0]   <= dz_b_q;
    nsg_q[0]  <= nsg_b_q;
    neg_q[0]  <= neg_b_q;
  end

  // One restoring step per stage.
  always_comb begin
    for (int k = 0; k < MAG_BITS; k++) begin
      trial[k] = {rem_q[k], lo_q[k][MAG_BITS-1]};
      take[k]  = (trial[k] >= {1'b0, m_q[k]});
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAG_BITS; k++) begin
      rem_q[k+1]  <= take[k] ? MAG_BITS'(trial[k] - {1'b0, m_q[k]}) : trial[k][MAG_BITS-1:0];
      quo_q[k+1]  <= {quo_q[k][MAG_BITS-2:0], take[k]};
      lo_q[k+1]   <= lo_q[k] << 1;
      m_q[k+1]    <= m_q[k];
      ovf_q[k+1]  <= ovf_q[k];
      zero_q[k+1] <= zero_q[k];
      dz_q[k+1]   <= dz_q[k];
      nsg_q[k+1]  <= nsg_q[k];
      neg_q[k+1]  <= neg_q[k];
    end
  end

  // Saturation, sign and the zero cases.
  assign lim_s = $signed({{(INT_BITS-MAG_BITS){1'b0}}, QUOT_LIM});

  always_comb begin
    mag_fin = (ovf_q[MAG_BITS] || (quo_q[MAG_BITS] > QUOT_LIM)) ? QUOT_LIM : quo_q[MAG_BITS];
    if (zero_q[MAG_BITS]) begin
      res_d = '0;
    end else if (dz_q[MAG_BITS]) begin
      res_d = nsg_q[MAG_BITS] ? -lim_s : lim_s;
    end else if (neg_q[MAG_BITS]) begin
      res_d = -$signed({{(INT_BITS-MAG_BITS){1'b0}}, mag_fin});
    end else begin
      res_d = $signed({{(INT_BITS-MAG_BITS){1'b0}}, mag_fin});
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign quot_o = res_q;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the rotated rectangle overlap test pipeline.
`timescale 1ns / 1ps

module testbench;
  import rro_pkg::*;

  typedef struct {
    logic signed [COORD_BITS-1:0] x1, y1;
    logic [SIZE_BITS-1:0]         w1, h1;
    logic [ANG_BITS-1:0]          a1;
    logic signed [COORD_BITS-1:0] x2, y2;
    logic [SIZE_BITS-1:0]         w2, h2;
    logic [ANG_BITS-1:0]          a2;
    bit                           drain_first;
  } rect_pair_t;

  logic clk_i, rst_ni, start, busy, done_o, overlap_o;
  logic signed [COORD_BITS-1:0] first_center_x_i, first_center_y_i;
  logic signed [COORD_BITS-1:0] second_center_x_i, second_center_y_i;
  logic [SIZE_BITS-1:0] first_width_i, first_height_i, second_width_i, second_height_i;
  logic [ANG_BITS-1:0] first_angle_i, second_angle_i;

  rect_pair_t pair_queue[$];
  bit         overlap_queue[$];
  rect_pair_t cur_pair;
  int         gap_cycles;
  int         error_count;
  bit         stimulus_done;

  rotated_rectangle_overlap_test dut (
    .clk_i, .rst_ni, .start, .busy,
    .first_center_x_i, .first_center_y_i, .first_width_i, .first_height_i,
    .first_angle_i, .second_center_x_i, .second_center_y_i, .second_width_i,
    .second_height_i, .second_angle_i, .done_o, .overlap_o
  );

  // Sine and cosine over one octant in Q30, truncating Taylor series.
  function automatic void octant_q30(input logic [63:0] r, output logic [63:0] s,
                                     output logic [63:0] c);
    logic [63:0] th, r2, h, one;
    one = 64'd1 << 30;
    th  = r * 64'd3373259426 / 64'd2880;
    r2  = (th * th) >> 30;
    h   = one - r2 / 110;
    h   = one - ((r2 * h) >> 30) / 72;
    h   = one - ((r2 * h) >> 30) / 42;
    h   = one - ((r2 * h) >> 30) / 20;
    h   = one - ((r2 * h) >> 30) / 6;
    s   = (th * h) >> 30;
    h   = one - r2 / 132;
    h   = one - ((r2 * h) >> 30) / 90;
    h   = one - ((r2 * h) >> 30) / 56;
    h   = one - ((r2 * h) >> 30) / 30;
    h   = one - ((r2 * h) >> 30) / 12;
    c   = one - ((r2 * h) >> 30) / 2;
  endfunction

  // Quantized sine and cosine of an angle in sixteenths of a degree.
  function automatic void angle_trig(input int q, output longint sn, output longint cs);
    int          quad, r;
    logic [63:0] s30, c30, half;
    longint      s, c;
    quad = (q / QUARTER_STEPS) % 4;
    r    = q % QUARTER_STEPS;
    half = 64'd1 << (29 - TRIG_FRAC_BITS);
    if (r <= EIGHTH_STEPS) octant_q30(r, s30, c30);
    else octant_q30(QUARTER_STEPS - r, c30, s30);
    s = longint'((s30 + half) >> (30 - TRIG_FRAC_BITS));
    c = longint'((c30 + half) >> (30 - TRIG_FRAC_BITS));
    case (quad)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  // Round a trig product to coordinate units (floor after adding half).
  function automatic longint trig_round(input longint v);
    return (v + (longint'(1) << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
  endfunction

  // n1 * n2 / d truncated toward zero, saturated at the quotient bound.
  function automatic longint interp_quot(input longint n1, input longint n2, input longint d);
    bit           neg;
    logic [127:0] prod, quo, lim;
    longint       p, q, m;
    lim = 128'd1 << (COORD_BITS + 4);
    neg = ((n1 < 0) != (n2 < 0)) != (d < 0);
    p = n1 < 0 ? -n1 : n1;
    q = n2 < 0 ? -n2 : n2;
    m = d < 0 ? -d : d;
    if (p == 0 || q == 0) return 0;
    if (m == 0) return ((n1 < 0) != (n2 < 0)) ? -longint'(lim) : longint'(lim);
    prod = 128'(p) * 128'(q);
    quo  = prod / 128'(m);
    if (quo > lim) quo = lim;
    return neg ? -longint'(quo) : longint'(quo);
  endfunction

  // Expected overlap flag for one rectangle pair.
  function automatic bit predict_overlap(input rect_pair_t pr);
    longint s2, c2, sd, cd, dx, dy, cx, cy, blx, bly, trx, try_;
    longint ax, ay, bx, by, tmp, e1, e2, xs, xa, den, w1, h1, w2, h2;
    int     a1, a2;
    bit     tneg, tzero;
    a1 = int'(pr.a1) % ANGLE_STEPS;
    a2 = int'(pr.a2) % ANGLE_STEPS;
    w1 = longint'(pr.w1); h1 = longint'(pr.h1);
    w2 = longint'(pr.w2); h2 = longint'(pr.h2);
    angle_trig(a2, s2, c2);
    angle_trig((a1 + ANGLE_STEPS - a2) % ANGLE_STEPS, sd, cd);
    dx  = 2 * (longint'(pr.x2) - longint'(pr.x1));
    dy  = 2 * (longint'(pr.y2) - longint'(pr.y1));
    cx  = trig_round(c2 * dx + s2 * dy);
    cy  = trig_round(c2 * dy - s2 * dx);
    blx = cx - w2; bly = cy - h2;
    trx = cx + w2; try_ = cy + h2;
    ax = trig_round(w1 * cd - h1 * sd);
    bx = trig_round(-h1 * sd - w1 * cd);
    ay = trig_round(h1 * cd + w1 * sd);
    by = trig_round(h1 * cd - w1 * sd);
    tzero = (sd == 0 || cd == 0);
    tneg  = !tzero && ((sd < 0) != (cd < 0));
    if (tneg) begin
      tmp = ax; ax = bx; bx = tmp;
      tmp = ay; ay = by; by = tmp;
    end
    if (sd < 0) begin
      bx = -bx; by = -by;
    end
    // Horizontal range rejection.
    if (bx > trx || bx > -blx) return 1'b0;
    if (tzero) begin
      e1 = ay; e2 = -ay;
    end else begin
      xs = blx - ax; xa = trx - ax; e1 = ay;
      if (xs != 0 && xa != 0 && ((xs < 0) == (xa < 0))) begin
        den = ax;
        if (xs < 0) begin den -= bx; e1 -= by; xs = xa; end
        else begin den += bx; e1 += by; end
        e1 = interp_quot(e1, xs, den) + ay;
      end
      xs = blx + ax; xa = trx + ax; e2 = -ay;
      if (xs != 0 && xa != 0 && ((xs < 0) == (xa < 0))) begin
        den = -ax;
        if (xs < 0) begin den -= bx; e2 -= by; xs = xa; end
        else begin den += bx; e2 += by; end
        e2 = interp_quot(e2, xs, den) - ay;
      end
    end
    return !((e1 < bly && e2 < bly) || (e1 > try_ && e2 > try_));
  endfunction

  function automatic rect_pair_t make_pair(
      input longint x1, y1, w1, h1, a1, x2, y2, w2, h2, a2);
    rect_pair_t pr;
    pr.x1 = x1; pr.y1 = y1; pr.w1 = w1; pr.h1 = h1; pr.a1 = a1;
    pr.x2 = x2; pr.y2 = y2; pr.w2 = w2; pr.h2 = h2; pr.a2 = a2;
    pr.drain_first = 1'b0;
    return pr;
  endfunction

  // Random pair: mostly nearby rectangles of similar size, some raw noise.
  function automatic rect_pair_t random_pair();
    rect_pair_t pr;
    int         scale;
    longint     bx, by;
    if ($urandom_range(3) == 0) begin
      pr = make_pair($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    end else begin
      scale = $urandom_range(4, 22);
      bx = $signed($urandom()) % (longint'(1) << 23);
      by = $signed($urandom()) % (longint'(1) << 23);
      pr = make_pair(bx, by,
                     $urandom_range(0, (1 << scale) - 1), $urandom_range(0, (1 << scale) - 1),
                     $urandom_range(0, 8191),
                     bx + $signed($urandom()) % (longint'(1) << scale),
                     by + $signed($urandom()) % (longint'(1) << scale),
                     $urandom_range(0, (1 << scale) - 1), $urandom_range(0, (1 << scale) - 1),
                     $urandom_range(0, 8191));
      // Occasionally quantize angles to right-angle multiples.
      if ($urandom_range(7) == 0) begin
        pr.a1 = QUARTER_STEPS * $urandom_range(0, 3);
        pr.a2 = QUARTER_STEPS * $urandom_range(0, 3);
      end
    end
    pr.drain_first = 1'b0;
    return pr;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stimulus: directed corner pairs, then random traffic.
  initial begin
    rect_pair_t pr;
    rst_ni = 1'b0;
    stimulus_done = 1'b0;
    pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pair_queue.push_back(make_pair(0, 0, 256, 256, 0, 0, 0, 256, 256, 0));
    pair_queue.push_back(make_pair(-8388608, -8388608, 8388607, 8388607, 5759,
                                   8388607, 8388607, 8388607, 8388607, 0));
    pair_queue.push_back(make_pair(8388607, -8388608, 8388607, 0, 8191,
                                   -8388608, 8388607, 0, 8388607, 8191));
    pair_queue.push_back(make_pair(0, 0, 1000, 500, 720, 1500, 0, 1000, 500, 0));
    pair_queue.push_back(make_pair(0, 0, 1000, 500, 1440, 0, 900, 300, 300, 2880));
    pair_queue.push_back(make_pair(0, 0, 1000, 500, 4320, 2000, 2000, 100, 100, 1440));
    pair_queue.push_back(make_pair(100, 100, 0, 0, 100, 100, 100, 0, 0, 100));
    pair_queue.push_back(make_pair(0, 0, 4096, 4096, 720, 3000, 3000, 4096, 4096, 720));
    pair_queue.push_back(make_pair(0, 0, 4096, 4096, 720, 5000, 0, 512, 512, 0));
    pair_queue.push_back(make_pair(0, 0, 4096, 100, 300, 2500, 800, 700, 700, 5000));
    pair_queue.push_back(make_pair(0, 0, 8388607, 8388607, 5760, 0, 0, 1, 1, 5761));
    pair_queue.push_back(make_pair(-5, 7, 3, 3, 2160, 5, -7, 3, 3, 3600));
    pair_queue.push_back(make_pair(0, 0, 2048, 2048, 1, 0, 2048, 2048, 2048, 5759));
    pair_queue.push_back(make_pair(0, 0, 2048, 0, 1440, 0, 0, 0, 2048, 0));
    for (int i = 0; i < 640; i++) begin
      pr = random_pair();
      // Let the pipeline drain completely at two points.
      if (i == 100 || i == 400) pr.drain_first = 1'b1;
      pair_queue.push_back(pr);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pair_queue.size() == 0 && !start);
    wait (overlap_queue.size() == 0);
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Driver: hold each pair until its transfer, then space the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      first_center_x_i <= '0; first_center_y_i <= '0;
      first_width_i <= '0; first_height_i <= '0; first_angle_i <= '0;
      second_center_x_i <= '0; second_center_y_i <= '0;
      second_width_i <= '0; second_height_i <= '0; second_angle_i <= '0;
      gap_cycles = 0;
    end else begin
      if (start && !busy) overlap_queue.push_back(predict_overlap(cur_pair));
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_cycles > 0) begin
        gap_cycles--;
        start <= 1'b0;
      end else if (pair_queue.size() != 0 &&
                   !(pair_queue[0].drain_first &&
                     (overlap_queue.size() != 0 || start))) begin
        cur_pair = pair_queue.pop_front();
        first_center_x_i <= cur_pair.x1; first_center_y_i <= cur_pair.y1;
        first_width_i <= cur_pair.w1; first_height_i <= cur_pair.h1;
        first_angle_i <= cur_pair.a1;
        second_center_x_i <= cur_pair.x2; second_center_y_i <= cur_pair.y2;
        second_width_i <= cur_pair.w2; second_height_i <= cur_pair.h2;
        second_angle_i <= cur_pair.a2;
        start <= 1'b1;
        gap_cycles = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    bit exp_overlap;
    if (rst_ni && done_o) begin
      if (overlap_queue.size() == 0) begin
        $error("Result transfer with no pair outstanding");
        error_count++;
      end else begin
        exp_overlap = overlap_queue.pop_front();
        if (overlap_o !== exp_overlap) begin
          $error("overlap mismatch: expected %0b, actual %0b", exp_overlap, overlap_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: rotated_rectangle_overlap_test.f
hw/rtl/rro_pkg.sv
hw/rtl/rro_div.sv
hw/rtl/rotated_rectangle_overlap_test.sv
verif/testbench.sv
